@@ rtl/pds_pkg.sv @@
`timescale 1ns / 1ps
package pds_pkg;
    localparam int NP = 32;
    localparam int NR = 64;
    localparam int PW = $clog2(NP);
    localparam int RW = $clog2(NR);

    localparam logic [1:0] ACT_DECL = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_FINISH = 2'd3;

    localparam logic [1:0] RK_BARRIER = 2'd0;
    localparam logic [1:0] RK_ORDER = 2'd1;
    localparam logic [1:0] RK_OK = 2'd2;
    localparam logic [1:0] RK_CYCLE = 2'd3;

    localparam logic [1:0] KIND_GFX = 2'd0;
    localparam logic [1:0] KIND_CMP = 2'd1;
    localparam logic [1:0] KIND_COPY = 2'd2;

    localparam logic [2:0] BC_DEPTH_SRV = 3'd0;
    localparam logic [2:0] BC_COLOR_SRV = 3'd1;
    localparam logic [2:0] BC_UAV_SRV = 3'd2;
    localparam logic [2:0] BC_COPY_SRV = 3'd3;
    localparam logic [2:0] BC_NOOP = 3'd4;

    localparam logic [11:0] STG_TOP = 12'h001;
    localparam logic [11:0] STG_FRAG = 12'h080;
    localparam logic [11:0] STG_LATE_DEPTH = 12'h200;
    localparam logic [11:0] STG_COLOR_OUT = 12'h400;
    localparam logic [11:0] STG_COMPUTE = 12'h800;
    localparam logic [10:0] ACC_SHADER_RD = 11'h020;
    localparam logic [10:0] ACC_SHADER_WR = 11'h040;
    localparam logic [10:0] ACC_COLOR_WR = 11'h100;
    localparam logic [10:0] ACC_DEPTH_WR = 11'h400;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] pass_index;
        logic [1:0] pass_kind;
        logic [5:0] resource_id;
        logic       surface;
        logic [5:0] pass_count;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [4:0]  prod_pass;
        logic [4:0]  cons_pass;
        logic [5:0]  barrier_resource;
        logic [2:0]  barrier_case;
        logic [11:0] src_stage_mask;
        logic [11:0] dst_stage_mask;
        logic [10:0] src_access_mask;
        logic [10:0] dst_access_mask;
        logic [2:0]  old_layout;
        logic [2:0]  new_layout;
        logic [1:0]  aspect_mask;
    } t_rsp;

    typedef struct packed {
        logic load;      // latch request
        logic access;    // apply decl/read/write
        logic clear;     // clear tables
        logic seed;      // seed step over scan index
        logic pop;       // pop fifo head into u
        logic scan;      // relax edge u->scan index
        logic emit;      // emit order entry at fifo index
        logic status;    // emit status
        logic send;      // output register load from barrier
    } t_cmd;

    typedef struct packed {
        logic       hit;        // read produced barrier
        logic       idx_last;   // scan index at end
        logic       fifo_empty; // head == tail
        logic       sorted_ok;  // tail == count
        logic       emit_last;  // emit index at tail-1
        logic       zero_cnt;
    } t_sts;

    function automatic t_rsp make_barrier(logic [4:0] prod, logic [4:0] cons,
                                          logic [5:0] res, logic [1:0] pk,
                                          logic [1:0] ck, logic depth);
        t_rsp r;
        logic cok;
        logic [11:0] dd;
        r = '0;
        cok = (ck == KIND_GFX) || (ck == KIND_CMP);
        dd = (ck == KIND_CMP) ? STG_COMPUTE : STG_FRAG;
        r.result_kind = RK_BARRIER;
        r.prod_pass = prod;
        r.cons_pass = cons;
        r.barrier_resource = res;
        if (cok && pk == KIND_GFX && depth) begin
            r.barrier_case = BC_DEPTH_SRV; r.src_stage_mask = STG_LATE_DEPTH;
            r.dst_stage_mask = dd; r.src_access_mask = ACC_DEPTH_WR;
            r.dst_access_mask = ACC_SHADER_RD; r.old_layout = 3'd3;
            r.new_layout = 3'd4; r.aspect_mask = 2'd2;
        end else if (cok && pk == KIND_GFX) begin
            r.barrier_case = BC_COLOR_SRV; r.src_stage_mask = STG_COLOR_OUT;
            r.dst_stage_mask = dd; r.src_access_mask = ACC_COLOR_WR;
            r.dst_access_mask = ACC_SHADER_RD; r.old_layout = 3'd2;
            r.new_layout = 3'd5; r.aspect_mask = 2'd1;
        end else if (cok && pk == KIND_CMP) begin
            r.barrier_case = BC_UAV_SRV; r.src_stage_mask = STG_COMPUTE;
            r.dst_stage_mask = (ck == KIND_GFX) ? STG_FRAG : STG_COMPUTE;
            r.src_access_mask = ACC_SHADER_WR;
            r.dst_access_mask = ACC_SHADER_RD; r.old_layout = 3'd1;
            r.new_layout = 3'd5; r.aspect_mask = 2'd1;
        end else if (cok && pk == KIND_COPY) begin
            r.barrier_case = BC_COPY_SRV; r.src_stage_mask = STG_LATE_DEPTH;
            r.dst_stage_mask = dd; r.src_access_mask = ACC_SHADER_WR;
            r.dst_access_mask = ACC_SHADER_RD; r.old_layout = 3'd7;
            r.new_layout = 3'd5; r.aspect_mask = 2'd1;
        end else begin
            r.barrier_case = BC_NOOP; r.src_stage_mask = STG_LATE_DEPTH;
            r.dst_stage_mask = STG_TOP;
        end
        return r;
    endfunction
endpackage

@@ rtl/pass_dependency_sorter.sv @@
`timescale 1ns / 1ps
// Pass dependency sorter.
// Input channel (i_valid / o_stall, payload i_req): declare, read, write and
// finish requests. An access request is latched in the idle state, which
// fetches the last writer of its resource; the access state then updates the
// edge matrix and, for a dependent read, loads one barrier into the output
// register once the output is free. Finish latches the request, seeds the
// ready queue over every pass index, then pops each ready pass and scans its
// edge row. With the queue empty it emits one order entry per sorted pass if
// all passes sorted, then the status, then idles through a wait state. The
// status step also clears the surface, writer-valid, edge and degree tables.
// Output channel (o_valid / i_stall, payload o_rsp): results leave through a
// single output register; while the receiver stalls the result holds and the
// block stops at the next point that would produce a result.
// Reset (i_rst_n, synchronous) clears the same tables and the output valid.
// Barriers sent before a cycle status stay sent; the consumer drops them.
module pass_dependency_sorter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pds_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output pds_pkg::t_rsp  o_rsp
);
    import pds_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Controller: sequence requests and the sort.
    pds_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_action(i_req.action), .i_sts(sts), .o_cmd(cmd),
        .o_valid(o_valid), .i_stall(i_stall)
    );

    // Datapath: tables, ready queue and output register.
    pds_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_cmd(cmd),
        .o_sts(sts), .o_rsp(o_rsp)
    );
endmodule

@@ rtl/pds_datapath.sv @@
`timescale 1ns / 1ps
module pds_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pds_pkg::t_req  i_req,
    input  pds_pkg::t_cmd  i_cmd,
    output pds_pkg::t_sts  o_sts,
    output pds_pkg::t_rsp  o_rsp
);
    import pds_pkg::*;

    t_req           r_req;
    logic [NR-1:0]  r_surf;
    logic [NR-1:0]  r_wvalid;
    logic [PW-1:0]  r_wpass [NR];
    logic [PW-1:0]  r_wp;
    logic [1:0]     r_kind [NP];
    logic [NP-1:0]  r_edge [NP];
    logic [5:0]     r_deg [NP];
    logic [5:0]     r_tdeg [NP];
    logic [PW-1:0]  r_fifo [NP];
    logic [PW:0]    r_head, r_tail, r_idx;
    logic [PW-1:0]  r_u;
    logic [PW:0]    r_cnt;
    t_rsp           r_rsp, n_rsp;

    logic [PW-1:0] wp;
    logic          hit;
    logic [PW-1:0] ix;

    // Last writer is fetched when the request is latched.
    assign wp  = r_wp;
    assign hit = (r_req.action == ACT_READ) && r_wvalid[r_req.resource_id]
                 && (wp != r_req.pass_index);
    assign ix  = r_idx[PW-1:0];

    assign o_sts.hit = hit;
    assign o_sts.idx_last = (r_idx == (PW+1)'(NP - 1));
    assign o_sts.fifo_empty = (r_head == r_tail);
    assign o_sts.sorted_ok = (r_tail == r_cnt);
    assign o_sts.emit_last = (r_idx + 1'b1 == r_tail);
    assign o_sts.zero_cnt = (r_tail == '0);
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_surf <= '0;
            r_wvalid <= '0;
            for (int i = 0; i < NP; i++) begin
                r_edge[i] <= '0;
                r_deg[i] <= '0;
            end
        end else if (i_cmd.access) begin
            case (r_req.action)
                ACT_DECL: r_surf[r_req.resource_id] <= r_req.surface;
                ACT_WRITE: begin
                    r_wvalid[r_req.resource_id] <= 1'b1;
                end
                ACT_READ: begin
                    if (hit && !r_edge[wp][r_req.pass_index]) begin
                        r_edge[wp][r_req.pass_index] <= 1'b1;
                        if (r_deg[r_req.pass_index] != 6'd63)
                            r_deg[r_req.pass_index] <= r_deg[r_req.pass_index] + 6'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_wp <= r_wpass[i_req.resource_id];
            r_cnt <= (i_req.pass_count > 6'(NP)) ? (PW+1)'(NP) : i_req.pass_count[PW:0];
        end
        if (i_cmd.access) begin
            if (r_req.action == ACT_WRITE) r_wpass[r_req.resource_id] <= r_req.pass_index;
            if (r_req.action != ACT_DECL) r_kind[r_req.pass_index] <= r_req.pass_kind;
        end
    end

    always_comb begin
        n_rsp = r_rsp;
        if (i_cmd.send) begin
            n_rsp = make_barrier(wp, r_req.pass_index, r_req.resource_id, r_kind[wp],
                                 r_req.pass_kind, r_surf[r_req.resource_id]);
        end else if (i_cmd.emit) begin
            n_rsp = '0;
            n_rsp.result_kind = RK_ORDER;
            n_rsp.cons_pass = r_fifo[ix];
        end else if (i_cmd.status) begin
            n_rsp = '0;
            n_rsp.result_kind = o_sts.sorted_ok ? RK_OK : RK_CYCLE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
            r_head <= '0;
            r_tail <= '0;
            for (int i = 0; i < NP; i++) r_tdeg[i] <= r_deg[i];
        end else if (i_cmd.seed) begin
            if ((r_idx < r_cnt) && r_tdeg[ix] == '0) begin
                r_fifo[r_tail[PW-1:0]] <= ix;
                r_tail <= r_tail + 1'b1;
            end
            r_idx <= o_sts.idx_last ? '0 : r_idx + 1'b1;
        end else if (i_cmd.pop) begin
            r_u <= r_fifo[r_head[PW-1:0]];
            r_head <= r_head + 1'b1;
            r_idx <= '0;
        end else if (i_cmd.scan) begin
            if (r_edge[r_u][ix] && r_tdeg[ix] != '0) begin
                r_tdeg[ix] <= r_tdeg[ix] - 6'd1;
                if (r_tdeg[ix] == 6'd1 && r_idx < r_cnt && r_tail < (PW+1)'(NP)) begin
                    r_fifo[r_tail[PW-1:0]] <= ix;
                    r_tail <= r_tail + 1'b1;
                end
            end
            r_idx <= o_sts.idx_last ? '0 : r_idx + 1'b1;
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end
endmodule

@@ rtl/pds_ctrl.sv @@
`timescale 1ns / 1ps
module pds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_action,
    input  pds_pkg::t_sts i_sts,
    output pds_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_stall
);
    import pds_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_ACC = 8'b00000010, S_SEED = 8'b00000100,
        S_POP = 8'b00001000, S_SCAN = 8'b00010000, S_EMIT = 8'b00100000,
        S_STAT = 8'b01000000, S_WAIT = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   free;

    assign free = !r_valid || !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_stall;
        o_cmd = '0;
        case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state = (i_action == ACT_FINISH) ? S_SEED : S_ACC;
            end
            S_ACC: if (!i_sts.hit) begin
                o_cmd.access = 1'b1;
                n_state = S_IDLE;
            end else if (free) begin
                o_cmd.send = 1'b1;
                o_cmd.access = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_sts.idx_last) n_state = S_POP;
            end
            S_POP: if (i_sts.fifo_empty) begin
                n_state = (i_sts.sorted_ok && !i_sts.zero_cnt) ? S_EMIT : S_STAT;
            end else begin
                o_cmd.pop = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.idx_last) n_state = S_POP;
            end
            S_EMIT: if (free) begin
                o_cmd.emit = 1'b1;
                n_valid = 1'b1;
                if (i_sts.emit_last) n_state = S_STAT;
            end
            S_STAT: if (free) begin
                o_cmd.status = 1'b1;
                o_cmd.clear = 1'b1;
                n_valid = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    property p_send_needs_room;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.send |-> free;
    endproperty
    a_send: assert property (p_send_needs_room) else $error("send over held result");

    property p_hold;
        @(posedge i_clk) disable iff (!i_rst_n) (r_valid && i_stall) |=> r_valid;
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped");

    property p_emit_one;
        @(posedge i_clk) disable iff (!i_rst_n)
            $countones({o_cmd.emit, o_cmd.status, o_cmd.send}) <= 1;
    endproperty
    a_one: assert property (p_emit_one) else $error("double output load");
endmodule

@@ dv/tb_pass_dependency_sorter.sv @@
`timescale 1ns / 1ps
module tb_pass_dependency_sorter;
    import pds_pkg::*;

    // Result store plus the graph predictor. Every accepted request goes
    // through note_request, which appends the results it should cause.
    class sorter_scoreboard;
        t_rsp       want_q[$];
        logic       surf_tab[NR];
        logic       wr_vld[NR];
        logic [4:0] wr_pass[NR];
        logic [1:0] kind_tab[NP];
        logic [NP-1:0] succ[NP];
        int         indeg[NP];
        int         n_err;

        function new();
            n_err = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < NR; i++) begin
                surf_tab[i] = 1'b0; wr_vld[i] = 1'b0; wr_pass[i] = '0;
            end
            for (int i = 0; i < NP; i++) begin
                kind_tab[i] = '0; succ[i] = '0; indeg[i] = 0;
            end
        endfunction

        // Pick one of the five barrier shapes from producer/consumer kind.
        function t_rsp barrier_for(int prod, int cons, int res, logic [1:0] pk,
                                   logic [1:0] ck, logic depth);
            t_rsp r;
            logic cok;
            logic [11:0] dd;
            r = '0;
            cok = (ck == KIND_GFX) || (ck == KIND_CMP);
            dd = (ck == KIND_CMP) ? STG_COMPUTE : STG_FRAG;
            r.result_kind = RK_BARRIER;
            r.prod_pass = prod[4:0];
            r.cons_pass = cons[4:0];
            r.barrier_resource = res[5:0];
            if (!cok) begin
                r.barrier_case = BC_NOOP; r.src_stage_mask = STG_LATE_DEPTH;
                r.dst_stage_mask = STG_TOP;
            end else begin
                r.dst_access_mask = ACC_SHADER_RD;
                r.dst_stage_mask = dd;
                r.new_layout = 3'd5;
                r.aspect_mask = 2'd1;
                case (pk)
                    KIND_GFX: begin
                        if (depth) begin
                            r.barrier_case = BC_DEPTH_SRV; r.src_stage_mask = STG_LATE_DEPTH;
                            r.src_access_mask = ACC_DEPTH_WR; r.old_layout = 3'd3;
                            r.new_layout = 3'd4; r.aspect_mask = 2'd2;
                        end else begin
                            r.barrier_case = BC_COLOR_SRV; r.src_stage_mask = STG_COLOR_OUT;
                            r.src_access_mask = ACC_COLOR_WR; r.old_layout = 3'd2;
                        end
                    end
                    KIND_CMP: begin
                        r.barrier_case = BC_UAV_SRV; r.src_stage_mask = STG_COMPUTE;
                        r.src_access_mask = ACC_SHADER_WR; r.old_layout = 3'd1;
                    end
                    KIND_COPY: begin
                        r.barrier_case = BC_COPY_SRV; r.src_stage_mask = STG_LATE_DEPTH;
                        r.src_access_mask = ACC_SHADER_WR; r.old_layout = 3'd7;
                    end
                    default: begin
                        r = '0;
                        r.result_kind = RK_BARRIER;
                        r.prod_pass = prod[4:0];
                        r.cons_pass = cons[4:0];
                        r.barrier_resource = res[5:0];
                        r.barrier_case = BC_NOOP; r.src_stage_mask = STG_LATE_DEPTH;
                        r.dst_stage_mask = STG_TOP;
                    end
                endcase
            end
            return r;
        endfunction

        // Kahn ordering: seed ascending, scan successors ascending.
        function void run_sort(int cnt);
            int deg[NP];
            int ready[$];
            int head;
            t_rsp r;
            if (cnt > NP) cnt = NP;
            for (int i = 0; i < NP; i++) deg[i] = indeg[i];
            for (int i = 0; i < cnt; i++) if (deg[i] == 0) ready = {ready, i};
            head = 0;
            while (head < ready.size()) begin
                int u;
                u = ready[head];
                head++;
                for (int v = 0; v < NP; v++) begin
                    if (succ[u][v] && deg[v] > 0) begin
                        deg[v]--;
                        if (deg[v] == 0 && v < cnt) ready = {ready, v};
                    end
                end
            end
            if (ready.size() == cnt) begin
                foreach (ready[i]) begin
                    r = '0; r.result_kind = RK_ORDER; r.cons_pass = ready[i][4:0];
                    want_q = {want_q, r};
                end
                r = '0; r.result_kind = RK_OK;
            end else begin
                r = '0; r.result_kind = RK_CYCLE;
            end
            want_q = {want_q, r};
            wipe();
        endfunction

        function void note_request(t_req q);
            int p, rid, u;
            p = q.pass_index;
            rid = q.resource_id;
            case (q.action)
                ACT_FINISH: run_sort(q.pass_count);
                ACT_DECL: surf_tab[rid] = q.surface;
                ACT_WRITE: begin
                    kind_tab[p] = q.pass_kind;
                    wr_vld[rid] = 1'b1;
                    wr_pass[rid] = q.pass_index;
                end
                default: begin
                    kind_tab[p] = q.pass_kind;
                    if (wr_vld[rid] && wr_pass[rid] != q.pass_index) begin
                        u = wr_pass[rid];
                        if (!succ[u][p]) begin
                            succ[u][p] = 1'b1;
                            if (indeg[p] < 63) indeg[p]++;
                        end
                        want_q = {want_q, barrier_for(u, p, rid, kind_tab[u],
                                                      q.pass_kind, surf_tab[rid])};
                    end
                end
            endcase
        endfunction

        function void check_result(t_rsp got);
            t_rsp w;
            if (want_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", got);
                return;
            end
            w = want_q.pop_front();
            if (got !== w) begin
                n_err++;
                if (n_err <= 10) $display("mismatch: expected %h got %h", w, got);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_rsp o_rsp;

    sorter_scoreboard sb;
    bit hold_out;     // long receiver hold-off request

    pass_dependency_sorter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req(i_req), .o_valid(o_valid), .i_stall(i_stall), .o_rsp(o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one request and hold it until accepted; score it at acceptance.
    // Valid stays high into the next request when there is no gap.
    task automatic send_request(t_req q, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(q);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.want_q.size() != 0);
    endtask

    function automatic t_req mk(logic [1:0] act, int p, int k, int rid, int s, int c);
        t_req q;
        q.action = act; q.pass_index = p[4:0]; q.pass_kind = k[1:0];
        q.resource_id = rid[5:0]; q.surface = s[0]; q.pass_count = c[5:0];
        return q;
    endfunction

    // Random noise: any field value at all.
    function automatic t_req noise_req();
        t_req q;
        logic [31:0] w;
        w = $urandom;
        q = w[$bits(t_req)-1:0];
        return q;
    endfunction

    // Graph: declares, then passes in ascending order, reads before writes,
    // on a small resource pool so reads hit writers, rare noise; finish.
    task automatic random_graph(ref int sent);
        int np, nres, base, cnt;
        t_req q;
        np = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32) : $urandom_range(2, 8);
        nres = $urandom_range(2, 8);
        base = $urandom_range(0, 63 - nres);
        for (int r = 0; r < nres; r++)
            if ($urandom_range(0, 1)) begin
                send_request(mk(ACT_DECL, 0, 0, base + r, $urandom_range(0, 1), 0), 1);
                sent++;
            end
        for (int p = 0; p < np; p++) begin
            int k;
            k = $urandom_range(0, 3);
            repeat ($urandom_range(0, 2)) begin
                send_request(mk(ACT_READ, p, k, base + $urandom_range(0, nres - 1), 0, 0), 1);
                sent++;
            end
            repeat ($urandom_range(0, 2)) begin
                send_request(mk(ACT_WRITE, p, k, base + $urandom_range(0, nres - 1), 0, 0), 1);
                sent++;
            end
            if ($urandom_range(0, 15) == 0) begin
                send_request(noise_req(), 1);
                sent++;
            end
        end
        case ($urandom_range(0, 7))
            0: cnt = $urandom_range(0, np);
            1: cnt = $urandom_range(33, 63);
            default: cnt = np;
        endcase
        send_request(mk(ACT_FINISH, 0, 0, 0, 0, cnt), 1);
        sent++;
    endtask

    // Receiver: random stalls, plus one forced long hold-off on request.
    initial begin
        bit held;
        held = 0;
        i_stall = 1'b1;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_out && !held) begin
                held = 1;
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (pick_gap()) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Score results as they are accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_rsp);
    end

    initial begin
        int sent;
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req = '0;
        hold_out = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every barrier shape, own-write read, no-writer read,
        // cycle, zero and saturated counts, max field values.
        send_request(mk(ACT_DECL, 31, 3, 63, 1, 63), 0);
        send_request(mk(ACT_READ, 3, 0, 9, 0, 0), 0);
        send_request(mk(ACT_WRITE, 0, KIND_GFX, 63, 0, 0), 0);
        send_request(mk(ACT_WRITE, 0, KIND_GFX, 1, 0, 0), 0);
        send_request(mk(ACT_READ, 0, KIND_GFX, 1, 0, 0), 0);
        send_request(mk(ACT_READ, 1, KIND_CMP, 63, 0, 0), 0);
        send_request(mk(ACT_READ, 1, KIND_CMP, 1, 0, 0), 0);
        send_request(mk(ACT_WRITE, 1, KIND_CMP, 2, 0, 0), 0);
        send_request(mk(ACT_READ, 2, KIND_GFX, 2, 0, 0), 0);
        send_request(mk(ACT_WRITE, 2, KIND_COPY, 3, 0, 0), 0);
        send_request(mk(ACT_READ, 31, 3, 3, 0, 0), 0);
        send_request(mk(ACT_READ, 4, KIND_CMP, 3, 0, 0), 0);
        send_request(mk(ACT_WRITE, 31, 3, 4, 0, 0), 0);
        send_request(mk(ACT_READ, 5, KIND_COPY, 4, 0, 0), 0);
        send_request(mk(ACT_FINISH, 0, 0, 0, 0, 63), 0);
        send_request(mk(ACT_FINISH, 0, 0, 0, 0, 0), 0);
        send_request(mk(ACT_WRITE, 1, KIND_GFX, 5, 0, 0), 0);
        send_request(mk(ACT_READ, 0, KIND_GFX, 5, 0, 0), 0);
        send_request(mk(ACT_WRITE, 0, KIND_GFX, 6, 0, 0), 0);
        send_request(mk(ACT_READ, 1, KIND_GFX, 6, 0, 0), 0);
        send_request(mk(ACT_FINISH, 0, 0, 0, 0, 2), 0);
        send_request(mk(ACT_FINISH, 0, 0, 0, 0, 32), 0);
        drain();

        // Back-pressure: hold the receiver while graphs keep coming.
        sent = 22;
        hold_out = 1;
        random_graph(sent);
        random_graph(sent);
        drain();

        while (sent < 400) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(noise_req(), 1);
                sent++;
            end else begin
                random_graph(sent);
            end
        end
        drain();
        repeat (2000) @(posedge i_clk);
        if (sb.n_err == 0 && sb.want_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: well past the slowest legal run.
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
